FILE: rtl/core/mpf_pkg.sv
// shared types, codes and saturating byte helpers of the profile filter
`default_nettype none

package mpf_pkg;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_RESIDUE = 1'b1;

    typedef enum logic [2:0] {
        CFG_EMISSION_BIAS = 3'd0,
        CFG_SCORE_BASE    = 3'd1,
        CFG_MOVE_COST     = 3'd2,
        CFG_END_COST      = 3'd3,
        CFG_MODEL_LENGTH  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        opcode;
        logic [4:0]  residue_code;
        logic [10:0] model_position;
        logic [7:0]  emission_score;
        logic        first_residue;
        logic        last_residue;
    } t_item;

    typedef struct packed {
        logic [7:0] final_j_score;
        logic       overflowed;
    } t_result;

    typedef struct packed {
        logic [2:0]  reg_index;
        logic [10:0] wr_data;
    } t_cfg_wr;

    typedef struct packed {
        logic issue;
        logic first_pos;
        logic last_pos;
        logic clear_fill;
    } t_row_ctl;

    typedef struct packed {
        logic       done;
        logic [7:0] e_max;
    } t_row_stat;

    function automatic logic [7:0] add_sat(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    function automatic logic [7:0] sub_sat(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : 8'h00;
    endfunction

    function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mpf_item_if.sv
// input word channel of the profile filter
`default_nettype none

interface mpf_item_if;
    logic           valid;
    logic           ready;
    mpf_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mpf_result_if.sv
// result word channel of the profile filter
`default_nettype none

interface mpf_result_if;
    logic             valid;
    logic             ready;
    mpf_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mpf_cfg_if.sv
// register write channel of the profile filter
`default_nettype none

interface mpf_cfg_if;
    logic             valid;
    logic             ready;
    mpf_pkg::t_cfg_wr data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mpf_emis_mem.sv
// emission cost memory, one write port and one registered read port
`default_nettype none

module mpf_emis_mem #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/mpf_row_unit.sv
// match row memory and the per-position update with running row maximum
`default_nettype none

module mpf_row_unit #(
    parameter int MAX_MODEL = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire mpf_pkg::t_row_ctl               i_ctl,
    input  wire logic [$clog2(MAX_MODEL)-1:0]    i_k,
    input  wire logic [7:0]                      i_b,
    input  wire logic [7:0]                      i_bias,
    input  wire logic [7:0]                      i_emis,
    output mpf_pkg::t_row_stat                   o_stat
);

    localparam int POS_W = $clog2(MAX_MODEL);
    localparam int LEN_W = POS_W + 1;

    logic [7:0]       r_mem [0:MAX_MODEL-1];
    logic [7:0]       r_row_q;
    logic             r_d_valid;
    logic [POS_W-1:0] r_d_k;
    logic             r_d_first;
    logic             r_d_last;
    logic [LEN_W-1:0] r_fill;
    logic [7:0]       r_prev;
    logic [7:0]       r_e;
    logic             r_done;

    logic [LEN_W-1:0] d_k_ext;
    logic [LEN_W-1:0] n_fill;
    logic [7:0]       row_old;
    logic [7:0]       prev_use;
    logic [7:0]       v;
    logic [7:0]       n_e;

    // entries at or past the fill mark were not written since the row was cleared
    always_comb begin
        d_k_ext  = {1'b0, r_d_k};
        n_fill   = d_k_ext + LEN_W'(1);
        row_old  = (d_k_ext >= r_fill) ? 8'h00 : r_row_q;
        prev_use = r_d_first ? 8'h00 : r_prev;
        v        = mpf_pkg::sub_sat(mpf_pkg::add_sat(mpf_pkg::max8(prev_use, i_b), i_bias),
                                    i_emis);
        n_e      = mpf_pkg::max8(r_d_first ? 8'h00 : r_e, v);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_row_q <= r_mem[i_k];
        end
        if (r_d_valid) begin
            r_mem[r_d_k] <= v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_d_first <= 1'b0;
            r_d_last  <= 1'b0;
            r_fill    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_d_valid <= i_ctl.issue;
            r_d_first <= i_ctl.first_pos;
            r_d_last  <= i_ctl.issue & i_ctl.last_pos;
            r_done    <= r_d_valid & r_d_last;
            if (i_ctl.clear_fill) begin
                r_fill <= '0;
            end else if (r_d_valid && (n_fill > r_fill)) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_k <= i_k;
        if (r_d_valid) begin
            r_prev <= row_old;
            r_e    <= n_e;
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.e_max = r_e;

endmodule

`default_nettype wire

FILE: rtl/core/msv_profile_filter.sv
// top level of the one-row match filter in saturating bytes
//
//  channel   dir  payload                                            handshake
//  i_item    in   opcode, residue, position, emission, first, last   valid / ready
//  o_result  out  final_j_score, overflowed                          valid / ready
//  i_cfg     in   reg_index, wr_data                                 valid / ready (always 1)
//
// a load word with position 1..MAX_MODEL writes the emission memory; the next word is not held
// a residue word makes one pass through the row memory port, one position per
// cycle, then the J and B update; in an overflowed sequence it skips both
// after reset the row reads as zero through a fill mark, so no clearing pass
// a finished result waits in an output register; only a later word that also
// closes a sequence waits for it to be taken
`default_nettype none

module msv_profile_filter #(
    parameter int MAX_MODEL     = 1024,
    parameter int ALPHABET_SIZE = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mpf_item_if.sink     i_item,
    mpf_result_if.source o_result,
    mpf_cfg_if.sink      i_cfg
);

    localparam int POS_W      = $clog2(MAX_MODEL);
    localparam int RES_W      = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int EMIS_AW    = RES_W + POS_W;
    localparam int EMIS_DEPTH = ALPHABET_SIZE * (2 ** POS_W);

    function automatic logic [RES_W-1:0] wrap_res(input logic [4:0] r);
        logic [5:0] w;
        w = {1'b0, r};
        for (int i = 0; i < 8; i++) begin
            if (w >= 6'(ALPHABET_SIZE)) begin
                w = w - 6'(ALPHABET_SIZE);
            end
        end
        return w[RES_W-1:0];
    endfunction

    mpf_pkg::t_state    r_state;
    mpf_pkg::t_state    n_state;
    mpf_pkg::t_row_ctl  row_ctl;
    mpf_pkg::t_row_stat row_stat;
    mpf_pkg::t_item     item;

    logic [7:0]       r_bias;
    logic [7:0]       r_base;
    logic [7:0]       r_move;
    logic [7:0]       r_end;
    logic [10:0]      r_len;
    logic [7:0]       r_j;
    logic [7:0]       r_b;
    logic             r_flag;
    logic [RES_W-1:0] r_res;
    logic             r_last;
    logic [POS_W-1:0] r_k;
    logic             r_issuing;
    logic             r_out_valid;
    logic [7:0]       r_out_j;
    logic             r_out_ovf;

    logic             item_ready;
    logic             item_acc;
    logic             load_acc;
    logic             res_acc;
    logic             out_load;
    logic             flag_eff;
    logic [31:0]      len_used;
    logic [31:0]      len_m1;
    logic [31:0]      pos_ext;
    logic [31:0]      pos_m1;
    logic             pos_ok;
    logic [POS_W-1:0] k_last;
    logic [7:0]       emis_q;
    logic [7:0]       j_new;
    logic             ovf_now;

    assign item     = i_item.data;
    assign item_acc = i_item.valid & item_ready;
    assign load_acc = item_acc & (item.opcode == mpf_pkg::OP_LOAD);
    assign res_acc  = item_acc & (item.opcode == mpf_pkg::OP_RESIDUE);
    assign flag_eff = item.first_residue ? 1'b0 : r_flag;

    always_comb begin
        len_used = 32'(r_len);
        if (r_len == 11'd0) begin
            len_used = 32'd1;
        end else if (32'(r_len) > 32'(MAX_MODEL)) begin
            len_used = 32'(MAX_MODEL);
        end
        len_m1  = len_used - 32'd1;
        k_last  = len_m1[POS_W-1:0];
        pos_ext = 32'(item.model_position);
        pos_m1  = pos_ext - 32'd1;
        pos_ok  = (pos_ext != 32'd0) && (pos_ext <= 32'(MAX_MODEL));
    end

    always_comb begin
        ovf_now = (mpf_pkg::add_sat(row_stat.e_max, r_bias) == 8'hFF);
        j_new   = mpf_pkg::max8(r_j, mpf_pkg::sub_sat(row_stat.e_max, r_end));
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        item_ready = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            mpf_pkg::S_IDLE: begin
                item_ready = 1'b1;
                if (res_acc) begin
                    n_state = flag_eff ? mpf_pkg::S_OUT : mpf_pkg::S_RUN;
                end
            end
            mpf_pkg::S_RUN: begin
                if (row_stat.done) begin
                    n_state = mpf_pkg::S_OUT;
                end
            end
            mpf_pkg::S_OUT: begin
                if (!r_last) begin
                    n_state = mpf_pkg::S_IDLE;
                end else if (!r_out_valid || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = mpf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mpf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        row_ctl.issue      = r_issuing;
        row_ctl.first_pos  = r_issuing & (r_k == '0);
        row_ctl.last_pos   = (r_k == k_last);
        row_ctl.clear_fill = res_acc & item.first_residue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= 8'h00;
            r_base <= 8'h00;
            r_move <= 8'h00;
            r_end  <= 8'h00;
            r_len  <= 11'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.reg_index)
                mpf_pkg::CFG_EMISSION_BIAS: r_bias <= i_cfg.data.wr_data[7:0];
                mpf_pkg::CFG_SCORE_BASE:    r_base <= i_cfg.data.wr_data[7:0];
                mpf_pkg::CFG_MOVE_COST:     r_move <= i_cfg.data.wr_data[7:0];
                mpf_pkg::CFG_END_COST:      r_end  <= i_cfg.data.wr_data[7:0];
                mpf_pkg::CFG_MODEL_LENGTH:  r_len  <= i_cfg.data.wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j         <= 8'h00;
            r_b         <= 8'h00;
            r_flag      <= 1'b0;
            r_issuing   <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (res_acc) begin
                r_last <= item.last_residue;
                if (item.first_residue) begin
                    r_j    <= 8'h00;
                    r_b    <= mpf_pkg::sub_sat(r_base, r_move);
                    r_flag <= 1'b0;
                end
                if (!flag_eff) begin
                    r_issuing <= 1'b1;
                end
            end else if (r_issuing && (r_k == k_last)) begin
                r_issuing <= 1'b0;
            end
            if ((r_state == mpf_pkg::S_RUN) && row_stat.done) begin
                if (ovf_now) begin
                    r_flag <= 1'b1;
                end else begin
                    r_j <= j_new;
                    r_b <= mpf_pkg::sub_sat(mpf_pkg::max8(r_base, j_new), r_move);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_acc) begin
            r_res <= wrap_res(item.residue_code);
            r_k   <= '0;
        end else if (r_issuing) begin
            r_k <= r_k + POS_W'(1);
        end
        if (out_load) begin
            r_out_j   <= r_flag ? 8'hFF : r_j;
            r_out_ovf <= r_flag;
        end
    end

    assign i_item.ready     = item_ready;
    assign i_cfg.ready      = 1'b1;
    assign o_result.valid   = r_out_valid;
    assign o_result.data.final_j_score = r_out_j;
    assign o_result.data.overflowed    = r_out_ovf;

    mpf_emis_mem #(
        .DEPTH (EMIS_DEPTH),
        .AW    (EMIS_AW)
    ) u_emis (
        .i_clk   (i_clk),
        .i_we    (load_acc & pos_ok),
        .i_waddr ({wrap_res(item.residue_code), pos_m1[POS_W-1:0]}),
        .i_wdata (item.emission_score),
        .i_re    (r_issuing),
        .i_raddr ({r_res, r_k}),
        .o_rdata (emis_q)
    );

    mpf_row_unit #(
        .MAX_MODEL (MAX_MODEL)
    ) u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (row_ctl),
        .i_k     (r_k),
        .i_b     (r_b),
        .i_bias  (r_bias),
        .i_emis  (emis_q),
        .o_stat  (row_stat)
    );

endmodule

`default_nettype wire

FILE: rtl/core/mpf_checker.sv
// port-level checks of the profile filter and their binding
`default_nettype none

module mpf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_opcode,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_j,
    input wire logic       i_out_ovf
);

    // an overflowed result carries the fixed byte
    a_ovf_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ovf) |-> (i_out_j == 8'hFF))
        else $error("overflowed result without saturated byte");

    // a residue word occupies the block for at least the next cycle
    a_residue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_opcode == mpf_pkg::OP_RESIDUE) |=> !i_in_ready)
        else $error("ready right after a residue word");

    // a load word never stalls the next one
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_opcode == mpf_pkg::OP_LOAD) |=> i_in_ready)
        else $error("not ready after a load word");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind msv_profile_filter mpf_checker u_mpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_opcode (i_item.data.opcode),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_j     (o_result.data.final_j_score),
    .i_out_ovf   (o_result.data.overflowed)
);

`default_nettype wire
